>>> rtl/jsev_pkg.sv
// jsev_pkg: shared types, codes and byte helpers for the JSON stream emitter.
// Used by jsev_ctrl, jsev_dp and the top module in rtl/. No dependencies.
package jsev_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int DIGITS          = 20;
	localparam int CONV_STEPS      = 64;

	localparam logic [5:0]  MAX_NEST_RESET = 6'd32;
	localparam logic [31:0] BUDGET_RESET   = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic CFG_MAX_NEST = 1'b0;
	localparam logic CFG_BUDGET   = 1'b1;

	// request codes
	localparam logic [3:0] REQ_OBJ_BEGIN = 4'd0;
	localparam logic [3:0] REQ_ARR_BEGIN = 4'd1;
	localparam logic [3:0] REQ_OBJ_END   = 4'd2;
	localparam logic [3:0] REQ_ARR_END   = 4'd3;
	localparam logic [3:0] REQ_KEY       = 4'd4;
	localparam logic [3:0] REQ_STRING    = 4'd5;
	localparam logic [3:0] REQ_NULL      = 4'd6;
	localparam logic [3:0] REQ_BOOL      = 4'd7;
	localparam logic [3:0] REQ_INT       = 4'd8;
	localparam logic [3:0] REQ_FINISH    = 4'd9;
	localparam logic [3:0] REQ_CLEAR     = 4'd10;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MISUSE    = 3'd1;
	localparam logic [2:0] ST_TOO_DEEP  = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE = 3'd3;
	localparam logic [2:0] ST_UNCLOSED  = 3'd4;

	// frame bits
	localparam int FR_OBJ      = 0;
	localparam int FR_KEY      = 1;
	localparam int FR_NONEMPTY = 2;

	// open piece kinds
	localparam logic [1:0] PIECE_NONE = 2'd0;
	localparam logic [1:0] PIECE_KEY  = 2'd1;
	localparam logic [1:0] PIECE_STR  = 2'd2;

	// literal codes
	localparam logic [1:0] LIT_NULL  = 2'd0;
	localparam logic [1:0] LIT_TRUE  = 2'd1;
	localparam logic [1:0] LIT_FALSE = 2'd2;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [7:0]  data_byte;
		logic        piece_first;
		logic        piece_last;
		logic        piece_empty;
		logic [63:0] int_bits;
		logic        int_unsigned;
		logic        bool_value;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [2:0] status;
		logic       last_of_item;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CONV,
		S_TRIM,
		S_PLAN,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		B_NONE,
		B_ESC,
		B_LIT,
		B_INT
	} body_t;

	typedef struct packed {
		logic accept;
		logic decode;
		logic conv;
		logic trim;
		logic plan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_int;
		logic conv_done;
		logic trim_done;
		logic emit_done;
	} dp_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? {4'h3, n} : 8'h57 + {4'h0, n};
	endfunction

	function automatic logic [7:0] esc_short(input logic [7:0] c);
		logic [7:0] s;
		case (c)
			8'h22: s = 8'h22;
			8'h5C: s = 8'h5C;
			8'h08: s = 8'h62;
			8'h0C: s = 8'h66;
			8'h0A: s = 8'h6E;
			8'h0D: s = 8'h72;
			8'h09: s = 8'h74;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] esc_len(input logic [7:0] c);
		logic [2:0] n;
		if (esc_short(c) != 8'h00) begin
			n = 3'd2;
		end else if (c < 8'h20) begin
			n = 3'd6;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

	function automatic logic [7:0] esc_byte(input logic [7:0] c, input logic [2:0] j);
		logic [7:0] s;
		logic [7:0] b;
		s = esc_short(c);
		if (s != 8'h00) begin
			b = (j == 3'd0) ? 8'h5C : s;
		end else if (c < 8'h20) begin
			case (j)
				3'd0: b = 8'h5C;
				3'd1: b = 8'h75;
				3'd2: b = 8'h30;
				3'd3: b = 8'h30;
				3'd4: b = hex_char(c[7:4]);
				default: b = hex_char(c[3:0]);
			endcase
		end else begin
			b = c;
		end
		return b;
	endfunction

	function automatic logic [7:0] lit_byte(input logic [1:0] code, input logic [2:0] j);
		logic [39:0] s;
		logic [7:0]  b;
		case (code)
			LIT_NULL: s = {"null", 8'h00};
			LIT_TRUE: s = {"true", 8'h00};
			default:  s = "false";
		endcase
		case (j)
			3'd0: b = s[39:32];
			3'd1: b = s[31:24];
			3'd2: b = s[23:16];
			3'd3: b = s[15:8];
			default: b = s[7:0];
		endcase
		return b;
	endfunction

endpackage

>>> rtl/jsev_ram.sv
// jsev_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module jsev_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/jsev_ctrl.sv
// jsev_ctrl: sequencer for decode, decimal conversion, budget planning and emission.
// Depends on jsev_pkg.
module jsev_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  jsev_pkg::dp_stat_t st,
	output jsev_pkg::cmd_t     cmd
);

	jsev_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsev_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jsev_pkg::S_IDLE: begin
				if (in_valid) state_d = jsev_pkg::S_DECODE;
			end
			jsev_pkg::S_DECODE: begin
				state_d = st.need_int ? jsev_pkg::S_CONV : jsev_pkg::S_PLAN;
			end
			jsev_pkg::S_CONV: begin
				if (st.conv_done) state_d = jsev_pkg::S_TRIM;
			end
			jsev_pkg::S_TRIM: begin
				if (st.trim_done) state_d = jsev_pkg::S_PLAN;
			end
			jsev_pkg::S_PLAN: begin
				state_d = jsev_pkg::S_EMIT;
			end
			jsev_pkg::S_EMIT: begin
				if (!out_stall && st.emit_done) state_d = jsev_pkg::S_IDLE;
			end
			default: state_d = jsev_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			jsev_pkg::S_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			jsev_pkg::S_DECODE: cmd.decode = 1'b1;
			jsev_pkg::S_CONV:   cmd.conv   = 1'b1;
			jsev_pkg::S_TRIM:   cmd.trim   = 1'b1;
			jsev_pkg::S_PLAN:   cmd.plan   = 1'b1;
			jsev_pkg::S_EMIT: begin
				out_valid = 1'b1;
				cmd.emit  = !out_stall;
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/jsev_dp.sv
// jsev_dp: datapath - config registers, nesting state, frame stack RAM,
// binary-to-decimal converter, budget check and byte emitter. Depends on jsev_pkg, jsev_ram.
module jsev_dp #(
	parameter int STACK_DEPTH = jsev_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  jsev_pkg::in_t      in_data,
	input  jsev_pkg::cmd_t     cmd,
	output jsev_pkg::dp_stat_t st,
	output jsev_pkg::out_t     out_data
);

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int BW = jsev_pkg::DIGITS * 4;

	logic [5:0]       max_nest_q;
	logic [31:0]      budget_q;
	jsev_pkg::in_t    in_q;
	logic [LW-1:0]    level_q;
	logic             root_q;
	logic [2:0]       stat_q;
	logic [31:0]      bw_q;
	logic [1:0]       popen_q;
	logic [2:0]       top_q;
	logic             reload_q;
	logic             plan_act_q;

	// token plan
	logic             comma_q, head_q, tail_q, colon_q;
	logic [7:0]       hbyte_q;
	jsev_pkg::body_t  bkind_q;
	logic [4:0]       blen_q;
	logic [1:0]       lit_q;
	logic             neg_q;
	logic [4:0]       bidx_q;
	logic [5:0]       ecnt_q;

	// decimal conversion
	logic [63:0]      bin_q;
	logic [BW-1:0]    bcd_q;
	logic [5:0]       cnt_q;
	logic [4:0]       nd_q;

	logic [2:0]       ram_rdata;

	// decode
	logic             t_obj, t_key, t_ne;
	logic             bv_fail, bv_comma, bv_root;
	logic [2:0]       bv_top;
	logic [3:0]       req;
	logic             active, is_clear, at_lim;
	logic [2:0]       lfail;
	logic             d_comma, d_head, d_tail, d_colon, d_push, d_pop, d_int;
	logic [7:0]       d_hbyte;
	jsev_pkg::body_t  d_bkind;
	logic [4:0]       d_blen;
	logic [1:0]       d_lit;
	logic [LW-1:0]    n_level;
	logic [2:0]       n_top;
	logic             n_root;
	logic [1:0]       n_popen;
	logic             first_e, last_e, is_key;
	logic [1:0]       kind;
	logic             dec_ok;
	logic [LW-1:0]    lvl_m1, lvl_m2;
	logic [63:0]      mag;

	assign t_obj  = top_q[jsev_pkg::FR_OBJ];
	assign t_key  = top_q[jsev_pkg::FR_KEY];
	assign t_ne   = top_q[jsev_pkg::FR_NONEMPTY];
	assign req    = in_q.req_type;
	assign lvl_m1 = level_q - LW'(1);
	assign lvl_m2 = level_q - LW'(2);

	always_comb begin
		bv_fail  = 1'b0;
		bv_comma = 1'b0;
		bv_root  = root_q | (level_q == '0);
		bv_top   = top_q;
		if (level_q == '0) begin
			bv_fail = root_q;
		end else if (t_obj) begin
			bv_fail = !t_key;
			bv_top  = 3'b101;
		end else begin
			bv_comma = t_ne;
			bv_top[jsev_pkg::FR_NONEMPTY] = 1'b1;
		end
	end

	assign at_lim = ({6'b0, level_q} >= {{LW{1'b0}}, max_nest_q})
		|| (level_q == LW'(STACK_DEPTH));
	assign is_clear = (req == jsev_pkg::REQ_CLEAR);
	assign active   = (stat_q == jsev_pkg::ST_OK) && (req <= jsev_pkg::REQ_FINISH);
	assign first_e  = in_q.piece_first | in_q.piece_empty;
	assign last_e   = in_q.piece_last | in_q.piece_empty;
	assign is_key   = (req == jsev_pkg::REQ_KEY);
	assign kind     = is_key ? jsev_pkg::PIECE_KEY : jsev_pkg::PIECE_STR;

	always_comb begin
		lfail   = jsev_pkg::ST_OK;
		d_comma = 1'b0;
		d_head  = 1'b0;
		d_hbyte = 8'h00;
		d_bkind = jsev_pkg::B_NONE;
		d_blen  = 5'd0;
		d_lit   = jsev_pkg::LIT_NULL;
		d_tail  = 1'b0;
		d_colon = 1'b0;
		d_push  = 1'b0;
		d_pop   = 1'b0;
		d_int   = 1'b0;
		n_level = level_q;
		n_top   = top_q;
		n_root  = root_q;
		n_popen = popen_q;
		if (active) begin
			if (popen_q != jsev_pkg::PIECE_NONE && req != jsev_pkg::REQ_KEY
				&& req != jsev_pkg::REQ_STRING) begin
				lfail = (req == jsev_pkg::REQ_FINISH) ? jsev_pkg::ST_UNCLOSED
					: jsev_pkg::ST_MISUSE;
			end else begin
				case (req)
					jsev_pkg::REQ_OBJ_BEGIN, jsev_pkg::REQ_ARR_BEGIN: begin
						if (at_lim) begin
							lfail = jsev_pkg::ST_TOO_DEEP;
						end else if (bv_fail) begin
							lfail = jsev_pkg::ST_MISUSE;
						end else begin
							d_comma = bv_comma;
							d_head  = 1'b1;
							d_hbyte = (req == jsev_pkg::REQ_OBJ_BEGIN) ? 8'h7B : 8'h5B;
							n_root  = bv_root;
							d_push  = 1'b1;
							n_top   = {2'b00, req == jsev_pkg::REQ_OBJ_BEGIN};
							n_level = level_q + LW'(1);
						end
					end
					jsev_pkg::REQ_OBJ_END, jsev_pkg::REQ_ARR_END: begin
						if (level_q == '0 || t_obj != (req == jsev_pkg::REQ_OBJ_END)
							|| t_key) begin
							lfail = jsev_pkg::ST_MISUSE;
						end else begin
							d_head  = 1'b1;
							d_hbyte = (req == jsev_pkg::REQ_OBJ_END) ? 8'h7D : 8'h5D;
							d_pop   = 1'b1;
							n_level = lvl_m1;
						end
					end
					jsev_pkg::REQ_KEY, jsev_pkg::REQ_STRING: begin
						if ((popen_q != jsev_pkg::PIECE_NONE && (popen_q != kind || first_e))
							|| (popen_q == jsev_pkg::PIECE_NONE && !first_e)) begin
							lfail = jsev_pkg::ST_MISUSE;
						end else begin
							if (first_e) begin
								if (is_key) begin
									if (level_q == '0 || !t_obj || t_key) begin
										lfail = jsev_pkg::ST_MISUSE;
									end else begin
										d_comma = t_ne;
									end
								end else if (bv_fail) begin
									lfail = jsev_pkg::ST_MISUSE;
								end else begin
									d_comma = bv_comma;
									n_root  = bv_root;
									n_top   = bv_top;
								end
								d_head  = 1'b1;
								d_hbyte = 8'h22;
							end
							if (!in_q.piece_empty) begin
								d_bkind = jsev_pkg::B_ESC;
								d_blen  = {2'b00, jsev_pkg::esc_len(in_q.data_byte)};
							end
							if (last_e) begin
								d_tail  = 1'b1;
								d_colon = is_key;
								if (is_key) n_top[jsev_pkg::FR_KEY] = 1'b1;
								n_popen = jsev_pkg::PIECE_NONE;
							end else begin
								n_popen = kind;
							end
						end
					end
					jsev_pkg::REQ_NULL, jsev_pkg::REQ_BOOL: begin
						if (bv_fail) begin
							lfail = jsev_pkg::ST_MISUSE;
						end else begin
							d_comma = bv_comma;
							n_root  = bv_root;
							n_top   = bv_top;
							d_bkind = jsev_pkg::B_LIT;
							if (req == jsev_pkg::REQ_NULL) begin
								d_lit  = jsev_pkg::LIT_NULL;
								d_blen = 5'd4;
							end else if (in_q.bool_value) begin
								d_lit  = jsev_pkg::LIT_TRUE;
								d_blen = 5'd4;
							end else begin
								d_lit  = jsev_pkg::LIT_FALSE;
								d_blen = 5'd5;
							end
						end
					end
					jsev_pkg::REQ_INT: begin
						if (bv_fail) begin
							lfail = jsev_pkg::ST_MISUSE;
						end else begin
							d_comma = bv_comma;
							n_root  = bv_root;
							n_top   = bv_top;
							d_bkind = jsev_pkg::B_INT;
							d_int   = 1'b1;
						end
					end
					jsev_pkg::REQ_FINISH: begin
						if (level_q != '0) begin
							lfail = jsev_pkg::ST_UNCLOSED;
						end else if (!root_q) begin
							lfail = jsev_pkg::ST_MISUSE;
						end
					end
					default: lfail = jsev_pkg::ST_OK;
				endcase
			end
		end
	end

	assign dec_ok = active && (lfail == jsev_pkg::ST_OK);
	assign mag    = (!in_q.int_unsigned && in_q.int_bits[63]) ? (~in_q.int_bits + 64'd1)
		: in_q.int_bits;

	// frame stack: entry i holds the frame of level i+1; top frame lives in top_q
	jsev_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (cmd.decode && dec_ok && d_push && level_q != '0),
		.waddr (lvl_m1[AW-1:0]),
		.wdata (bv_top),
		.raddr (lvl_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	// decimal conversion step: add 3 to digits of 5 or more, then shift
	logic [BW-1:0] bcd_adj;
	always_comb begin
		for (int i = 0; i < jsev_pkg::DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	// budget planning
	logic [31:0] rem;
	logic [4:0]  blen_eff;
	logic [5:0]  c1, c2, c3, c4, c5, n_emit;
	logic        ok1, ok2, ok3, ok4, ok5;

	assign rem      = (bw_q > budget_q) ? 32'd0 : budget_q - bw_q;
	assign blen_eff = (bkind_q == jsev_pkg::B_INT) ? nd_q + {4'd0, neg_q} : blen_q;
	assign c1 = {5'd0, comma_q};
	assign c2 = c1 + {5'd0, head_q};
	assign c3 = c2 + {1'b0, blen_eff};
	assign c4 = c3 + {5'd0, tail_q};
	assign c5 = c4 + {5'd0, colon_q};
	assign ok1 = {26'd0, c1} <= rem;
	assign ok2 = {26'd0, c2} <= rem;
	assign ok3 = {26'd0, c3} <= rem;
	assign ok4 = {26'd0, c4} <= rem;
	assign ok5 = {26'd0, c5} <= rem;
	assign n_emit = ok5 ? c5 : ok4 ? c4 : ok3 ? c3 : ok2 ? c2 : ok1 ? c1 : 6'd0;

	// emitter byte select
	logic       in_body;
	logic [7:0] body_byte, sel_byte;
	assign in_body = bidx_q < blen_q;
	always_comb begin
		case (bkind_q)
			jsev_pkg::B_ESC: body_byte = jsev_pkg::esc_byte(in_q.data_byte, bidx_q[2:0]);
			jsev_pkg::B_LIT: body_byte = jsev_pkg::lit_byte(lit_q, bidx_q[2:0]);
			jsev_pkg::B_INT: body_byte = neg_q ? 8'h2D : {4'h3, bcd_q[BW-1 -: 4]};
			default:         body_byte = 8'h00;
		endcase
		if (comma_q) begin
			sel_byte = 8'h2C;
		end else if (head_q) begin
			sel_byte = hbyte_q;
		end else if (in_body) begin
			sel_byte = body_byte;
		end else if (tail_q) begin
			sel_byte = 8'h22;
		end else begin
			sel_byte = 8'h3A;
		end
	end

	assign out_data.out_byte     = (ecnt_q != 6'd0) ? sel_byte : 8'h00;
	assign out_data.byte_valid   = (ecnt_q != 6'd0);
	assign out_data.status       = stat_q;
	assign out_data.last_of_item = (ecnt_q <= 6'd1);

	assign st.need_int  = dec_ok && d_int;
	assign st.conv_done = (cnt_q == 6'(jsev_pkg::CONV_STEPS - 1));
	assign st.trim_done = (nd_q == 5'd1) || (bcd_q[BW-1 -: 4] != 4'd0);
	assign st.emit_done = (ecnt_q <= 6'd1);

	// config and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nest_q <= jsev_pkg::MAX_NEST_RESET;
			budget_q   <= jsev_pkg::BUDGET_RESET;
			level_q    <= '0;
			root_q     <= 1'b0;
			stat_q     <= jsev_pkg::ST_OK;
			bw_q       <= 32'd0;
			popen_q    <= jsev_pkg::PIECE_NONE;
			reload_q   <= 1'b0;
			plan_act_q <= 1'b0;
			ecnt_q     <= 6'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					jsev_pkg::CFG_MAX_NEST: max_nest_q <= cfg_data[5:0];
					jsev_pkg::CFG_BUDGET:   budget_q   <= cfg_data;
					default: ;
				endcase
			end
			reload_q <= cmd.decode && dec_ok && d_pop && (level_q > LW'(1));
			if (cmd.decode) begin
				if (is_clear) begin
					level_q    <= '0;
					root_q     <= 1'b0;
					stat_q     <= jsev_pkg::ST_OK;
					bw_q       <= 32'd0;
					popen_q    <= jsev_pkg::PIECE_NONE;
					plan_act_q <= 1'b0;
				end else begin
					if (lfail != jsev_pkg::ST_OK) stat_q <= lfail;
					plan_act_q <= dec_ok;
					if (dec_ok) begin
						level_q <= n_level;
						root_q  <= n_root;
						popen_q <= n_popen;
					end
				end
			end
			if (cmd.plan) begin
				if (plan_act_q) begin
					ecnt_q <= n_emit;
					bw_q   <= bw_q + {26'd0, n_emit};
					if (!ok5) stat_q <= jsev_pkg::ST_TOO_LARGE;
				end else begin
					ecnt_q <= 6'd0;
				end
			end
			if (cmd.emit && ecnt_q != 6'd0) begin
				ecnt_q <= ecnt_q - 6'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= in_data;
		end
		if (reload_q) begin
			top_q <= ram_rdata;
		end
		if (cmd.decode) begin
			if (dec_ok) top_q <= n_top;
			comma_q <= d_comma;
			head_q  <= d_head;
			hbyte_q <= d_hbyte;
			bkind_q <= d_bkind;
			blen_q  <= d_blen;
			lit_q   <= d_lit;
			tail_q  <= d_tail;
			colon_q <= d_colon;
			bidx_q  <= 5'd0;
			neg_q   <= !in_q.int_unsigned && in_q.int_bits[63];
			bin_q   <= mag;
			bcd_q   <= '0;
			cnt_q   <= 6'd0;
			nd_q    <= 5'(jsev_pkg::DIGITS);
		end
		if (cmd.conv) begin
			{bcd_q, bin_q} <= {bcd_adj[BW-2:0], bin_q, 1'b0};
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.trim && !st.trim_done) begin
			bcd_q <= {bcd_q[BW-5:0], 4'h0};
			nd_q  <= nd_q - 5'd1;
		end
		if (cmd.plan) begin
			blen_q <= blen_eff;
		end
		if (cmd.emit) begin
			if (comma_q) begin
				comma_q <= 1'b0;
			end else if (head_q) begin
				head_q <= 1'b0;
			end else if (in_body) begin
				bidx_q <= bidx_q + 5'd1;
				if (bkind_q == jsev_pkg::B_INT) begin
					if (neg_q) begin
						neg_q <= 1'b0;
					end else begin
						bcd_q <= {bcd_q[BW-5:0], 4'h0};
					end
				end
			end else if (tail_q) begin
				tail_q <= 1'b0;
			end else begin
				colon_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/json_stream_emitter_validator_top.sv
// json_stream_emitter_validator_top: streaming JSON writer with misuse checking.
// Depends on jsev_pkg, jsev_ctrl, jsev_dp (and jsev_ram through jsev_dp).
//  - Input channel (in_valid/in_stall/in_data): one JSON writing event per
//    transaction. Key and string text arrives one byte per transaction.
//  - Output channel (out_valid/out_stall/out_data): one transaction per JSON
//    byte produced; an event that yields no byte gives one status-only
//    transaction. last_of_item marks the final transaction of each event,
//    and every transaction of an event carries the sticky status after it.
//  - Config port (cfg_we/cfg_index/cfg_data): index 0 max nesting, index 1
//    byte budget. Write only while the block is idle.
//  - Events are handled one at a time. After acceptance each event is decoded
//    and budget-planned, then it emits its output transactions in order.
//  - Integer events also run the shift/add binary-to-decimal converter on the
//    64-bit magnitude, then strip leading zeros one digit per cycle.
//  - A stalled output holds its transaction; in_stall stays high until the
//    last result of the current event is taken.
//  - Reset restores the register defaults and clears all nesting state;
//    the frame stack RAM needs no clearing since it is read only below the
//    current nesting level.
module json_stream_emitter_validator_top #(
	parameter int STACK_DEPTH = jsev_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  jsev_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output jsev_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data
);

	jsev_pkg::cmd_t     cmd;
	jsev_pkg::dp_stat_t st;

	// sequencer: owns both handshakes
	jsev_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: state, stack, decimal converter, emitter
	jsev_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule

>>> tb/json_stream_emitter_validator_top_tb.sv
// Testbench for json_stream_emitter_validator_top: random and directed JSON events
// are checked against an in-bench emitter model. Depends on jsev_pkg and the RTL.
`timescale 1ns / 100ps

module json_stream_emitter_validator_top_tb;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_stall;
	jsev_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	jsev_pkg::out_t out_data;
	logic           cfg_we    = 1'b0;
	logic           cfg_index = jsev_pkg::CFG_MAX_NEST;
	logic [31:0]    cfg_data  = '0;

	json_stream_emitter_validator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Emitter model: nesting stack, sticky status, budget and registers
	// ---------------------------------------------------------------
	logic [2:0]  frames [jsev_pkg::STACK_DEPTH_DEF];
	int          lvl;
	bit          root_done;
	logic [2:0]  sticky;
	logic [31:0] used;
	logic [1:0]  piece_kind;
	logic [5:0]  nest_cfg;
	logic [31:0] budget_cfg;

	logic [7:0]     text_q [$];        // bytes produced by the event being modeled
	jsev_pkg::out_t pending_bytes [$]; // expected output transactions, oldest first

	int  fails = 0;
	bit  quiet = 1'b0;            // no idling on either side while set
	bit  hold_off = 1'b0;         // receiver holds off while set

	function automatic void set_fail(logic [2:0] s);
		if (sticky == jsev_pkg::ST_OK) sticky = s;
	endfunction

	// Token is written whole or not at all
	function automatic bit put_tok(logic [7:0] tok [$]);
		if (sticky != jsev_pkg::ST_OK) return 1'b0;
		if (used > budget_cfg || longint'(tok.size()) > longint'(budget_cfg - used)) begin
			set_fail(jsev_pkg::ST_TOO_LARGE);
			return 1'b0;
		end
		foreach (tok[i]) text_q.push_back(tok[i]);
		used += tok.size();
		return 1'b1;
	endfunction

	function automatic bit put1(logic [7:0] c);
		logic [7:0] q [$];
		q.push_back(c);
		return put_tok(q);
	endfunction

	function automatic bit put_str(string s);
		logic [7:0] q [$];
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return put_tok(q);
	endfunction

	function automatic logic [7:0] nib_char(logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h57 + {4'h0, n};
	endfunction

	// Comma / key bookkeeping ahead of any value
	function automatic bit value_slot();
		logic [2:0] f;
		if (lvl == 0) begin
			if (root_done) begin
				set_fail(jsev_pkg::ST_MISUSE);
				return 1'b0;
			end
			root_done = 1'b1;
			return 1'b1;
		end
		f = frames[lvl-1];
		if (f[jsev_pkg::FR_OBJ]) begin
			if (!f[jsev_pkg::FR_KEY]) begin
				set_fail(jsev_pkg::ST_MISUSE);
				return 1'b0;
			end
			f[jsev_pkg::FR_KEY] = 1'b0;
			f[jsev_pkg::FR_NONEMPTY] = 1'b1;
			frames[lvl-1] = f;
			return 1'b1;
		end
		if (f[jsev_pkg::FR_NONEMPTY] && !put1(",")) return 1'b0;
		frames[lvl-1][jsev_pkg::FR_NONEMPTY] = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit put_escaped(logic [7:0] c);
		logic [7:0] q [$];
		logic [7:0] s;
		case (c)
			8'h22: s = 8'h22;
			8'h5C: s = 8'h5C;
			8'h08: s = "b";
			8'h0C: s = "f";
			8'h0A: s = "n";
			8'h0D: s = "r";
			8'h09: s = "t";
			default: s = 8'h00;
		endcase
		if (s != 8'h00) begin
			q.push_back(8'h5C);
			q.push_back(s);
			return put_tok(q);
		end
		if (c < 8'h20) begin
			q.push_back(8'h5C);
			q.push_back("u");
			q.push_back("0");
			q.push_back("0");
			q.push_back(nib_char(c[7:4]));
			q.push_back(nib_char(c[3:0]));
			return put_tok(q);
		end
		return put1(c);
	endfunction

	function automatic void open_container(bit obj);
		int lim;
		lim = (nest_cfg > jsev_pkg::STACK_DEPTH_DEF) ? jsev_pkg::STACK_DEPTH_DEF : nest_cfg;
		if (lvl >= lim) begin
			set_fail(jsev_pkg::ST_TOO_DEEP);
			return;
		end
		if (!value_slot()) return;
		frames[lvl] = obj ? (3'b1 << jsev_pkg::FR_OBJ) : 3'b0;
		lvl++;
		void'(put1(obj ? "{" : "["));
	endfunction

	function automatic void close_container(bit obj);
		logic [2:0] f;
		if (lvl == 0) begin
			set_fail(jsev_pkg::ST_MISUSE);
			return;
		end
		f = frames[lvl-1];
		if (f[jsev_pkg::FR_OBJ] != obj || f[jsev_pkg::FR_KEY]) begin
			set_fail(jsev_pkg::ST_MISUSE);
			return;
		end
		lvl--;
		void'(put1(obj ? "}" : "]"));
	endfunction

	function automatic void text_piece(bit is_key, jsev_pkg::in_t x);
		logic [1:0] kind;
		logic [2:0] f;
		bit first, last;
		kind  = is_key ? jsev_pkg::PIECE_KEY : jsev_pkg::PIECE_STR;
		first = x.piece_first | x.piece_empty;
		last  = x.piece_last | x.piece_empty;
		if ((piece_kind != jsev_pkg::PIECE_NONE && (piece_kind != kind || first)) ||
		    (piece_kind == jsev_pkg::PIECE_NONE && !first)) begin
			set_fail(jsev_pkg::ST_MISUSE);
			return;
		end
		if (first) begin
			if (is_key) begin
				if (lvl == 0) begin
					set_fail(jsev_pkg::ST_MISUSE);
					return;
				end
				f = frames[lvl-1];
				if (!f[jsev_pkg::FR_OBJ] || f[jsev_pkg::FR_KEY]) begin
					set_fail(jsev_pkg::ST_MISUSE);
					return;
				end
				if (f[jsev_pkg::FR_NONEMPTY] && !put1(",")) return;
			end else if (!value_slot()) begin
				return;
			end
			if (!put1(8'h22)) return;
			piece_kind = kind;
		end
		if (!x.piece_empty && !put_escaped(x.data_byte)) return;
		if (last) begin
			if (!put1(8'h22)) return;
			if (is_key) begin
				if (!put1(":")) return;
				if (lvl != 0) frames[lvl-1][jsev_pkg::FR_KEY] = 1'b1;
			end
			piece_kind = jsev_pkg::PIECE_NONE;
		end
	endfunction

	function automatic void decimal(logic [63:0] v, bit uns);
		logic [7:0] q [$];
		if (!value_slot()) return;
		if (!uns && v[63]) begin
			q.push_back("-");
			v = -v;
		end
		do begin
			q.insert((q.size() != 0 && q[0] == "-") ? 1 : 0, 8'h30 + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		void'(put_tok(q));
	endfunction

	// Model one accepted event and queue the output transactions it causes
	function automatic void predict_event(jsev_pkg::in_t x);
		jsev_pkg::out_t r;
		text_q.delete();
		if (x.req_type == jsev_pkg::REQ_CLEAR) begin
			lvl = 0;
			root_done = 1'b0;
			sticky = jsev_pkg::ST_OK;
			used = '0;
			piece_kind = jsev_pkg::PIECE_NONE;
		end else if (sticky == jsev_pkg::ST_OK && x.req_type <= jsev_pkg::REQ_FINISH) begin
			if (piece_kind != jsev_pkg::PIECE_NONE && x.req_type != jsev_pkg::REQ_KEY
			    && x.req_type != jsev_pkg::REQ_STRING) begin
				set_fail(x.req_type == jsev_pkg::REQ_FINISH ? jsev_pkg::ST_UNCLOSED
				         : jsev_pkg::ST_MISUSE);
			end else begin
				case (x.req_type)
					jsev_pkg::REQ_OBJ_BEGIN: open_container(1'b1);
					jsev_pkg::REQ_ARR_BEGIN: open_container(1'b0);
					jsev_pkg::REQ_OBJ_END:   close_container(1'b1);
					jsev_pkg::REQ_ARR_END:   close_container(1'b0);
					jsev_pkg::REQ_KEY:       text_piece(1'b1, x);
					jsev_pkg::REQ_STRING:    text_piece(1'b0, x);
					jsev_pkg::REQ_NULL:      if (value_slot()) void'(put_str("null"));
					jsev_pkg::REQ_BOOL: begin
						if (value_slot()) void'(put_str(x.bool_value ? "true" : "false"));
					end
					jsev_pkg::REQ_INT:       decimal(x.int_bits, x.int_unsigned);
					default: begin
						if (lvl != 0) set_fail(jsev_pkg::ST_UNCLOSED);
						else if (!root_done) set_fail(jsev_pkg::ST_MISUSE);
					end
				endcase
			end
		end
		if (text_q.size() == 0) begin
			r = '{out_byte: 8'h00, byte_valid: 1'b0, status: sticky, last_of_item: 1'b1};
			pending_bytes.push_back(r);
		end else begin
			foreach (text_q[i]) begin
				r = '{out_byte: text_q[i], byte_valid: 1'b1, status: sticky,
				      last_of_item: (i == text_q.size() - 1)};
				pending_bytes.push_back(r);
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Output side: checker plus receiver stall pattern, one edge process
	// ---------------------------------------------------------------
	int rx_gap = 0;

	always @(posedge clk) begin
		jsev_pkg::out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
				fails++;
			end else begin
				e = pending_bytes.pop_front();
				if (out_data.byte_valid !== e.byte_valid) begin
					$display("%0t: byte_valid expected %0b actual %0b", $time,
					         e.byte_valid, out_data.byte_valid);
					fails++;
				end
				if (out_data.out_byte !== e.out_byte) begin
					$display("%0t: out_byte expected %h actual %h", $time,
					         e.out_byte, out_data.out_byte);
					fails++;
				end
				if (out_data.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
					         e.status, out_data.status);
					fails++;
				end
				if (out_data.last_of_item !== e.last_of_item) begin
					$display("%0t: last_of_item expected %0b actual %0b", $time,
					         e.last_of_item, out_data.last_of_item);
					fails++;
				end
			end
			rx_gap = quiet ? 0 : $urandom_range(0, 18);
		end
		if (hold_off) begin
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Input side and register helpers
	// ---------------------------------------------------------------
	task automatic send_event(jsev_pkg::in_t x);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= x;
		do @(posedge clk); while (in_stall);
		predict_event(x);
	endtask

	// Drain: nothing pending, then allow for an integer conversion in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == jsev_pkg::CFG_MAX_NEST) nest_cfg = val[5:0];
		else budget_cfg = val;
	endtask

	function automatic jsev_pkg::in_t ev(logic [3:0] req, logic [7:0] d = 8'h00, bit f = 0,
	                                     bit l = 0, bit em = 0, logic [63:0] iv = '0,
	                                     bit u = 0, bit b = 0);
		jsev_pkg::in_t x;
		x = '{req_type: req, data_byte: d, piece_first: f, piece_last: l, piece_empty: em,
		      int_bits: iv, int_unsigned: u, bool_value: b};
		return x;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] sp [9] = '{8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h00, 8'h1F};
		if ($urandom_range(0, 3) == 0) return sp[$urandom_range(0, 8)];
		return 8'($urandom);
	endfunction

	// Mostly well-formed next event from the model's view, some noise
	function automatic jsev_pkg::in_t next_event();
		jsev_pkg::in_t x;
		logic [95:0]   raw;
		int r;
		raw = {$urandom, $urandom, $urandom};
		x = raw[$bits(jsev_pkg::in_t)-1:0];
		x.piece_empty = 1'b0;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			x.req_type = 4'($urandom_range(0, 15));
			x.piece_empty = 1'($urandom_range(0, 1));
		end else if (sticky != jsev_pkg::ST_OK) begin
			x.req_type = jsev_pkg::REQ_CLEAR;
		end else if (piece_kind != jsev_pkg::PIECE_NONE) begin
			x.req_type    = (piece_kind == jsev_pkg::PIECE_KEY) ? jsev_pkg::REQ_KEY
				: jsev_pkg::REQ_STRING;
			x.data_byte   = pick_byte();
			x.piece_first = 1'b0;
			x.piece_last  = ($urandom_range(0, 3) == 0);
		end else if (lvl == 0 && root_done) begin
			x.req_type = (r < 75) ? jsev_pkg::REQ_FINISH : jsev_pkg::REQ_CLEAR;
		end else if (lvl != 0 && frames[lvl-1][jsev_pkg::FR_OBJ]
		             && !frames[lvl-1][jsev_pkg::FR_KEY]) begin
			if (r < 22) begin
				x.req_type = jsev_pkg::REQ_OBJ_END;
			end else begin
				x.req_type    = jsev_pkg::REQ_KEY;
				x.data_byte   = pick_byte();
				x.piece_first = 1'b1;
				x.piece_last  = ($urandom_range(0, 2) == 0);
				x.piece_empty = ($urandom_range(0, 9) == 0);
			end
		end else if (lvl != 0 && !frames[lvl-1][jsev_pkg::FR_OBJ] && r < 12 + 4 * lvl) begin
			x.req_type = jsev_pkg::REQ_ARR_END;
		end else begin
			case ($urandom_range(0, 6))
				0: x.req_type = jsev_pkg::REQ_OBJ_BEGIN;
				1: x.req_type = jsev_pkg::REQ_ARR_BEGIN;
				2, 3: begin
					x.req_type    = jsev_pkg::REQ_STRING;
					x.data_byte   = pick_byte();
					x.piece_first = 1'b1;
					x.piece_last  = ($urandom_range(0, 2) == 0);
					x.piece_empty = ($urandom_range(0, 9) == 0);
				end
				4: x.req_type = jsev_pkg::REQ_NULL;
				5: x.req_type = jsev_pkg::REQ_BOOL;
				default: begin
					x.req_type = jsev_pkg::REQ_INT;
					if ($urandom_range(0, 2) == 0) x.int_bits = 64'($urandom_range(0, 99));
				end
			endcase
		end
		return x;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_document();
		send_event(ev(jsev_pkg::REQ_CLEAR));
		send_event(ev(jsev_pkg::REQ_OBJ_BEGIN));
		send_event(ev(jsev_pkg::REQ_KEY, 8'h22, 1, 1));
		send_event(ev(jsev_pkg::REQ_STRING, 8'h01, 1, 0));
		send_event(ev(jsev_pkg::REQ_STRING, 8'h0A, 0, 0));
		send_event(ev(jsev_pkg::REQ_STRING, 8'hFF, 0, 1));
		send_event(ev(jsev_pkg::REQ_KEY, 8'h00, 0, 0, 1));
		send_event(ev(jsev_pkg::REQ_INT, 8'h00, 0, 0, 0, 64'h8000_0000_0000_0000, 0));
		send_event(ev(jsev_pkg::REQ_KEY, "b", 1, 1));
		send_event(ev(jsev_pkg::REQ_INT, 8'h00, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1));
		send_event(ev(jsev_pkg::REQ_KEY, "c", 1, 1));
		send_event(ev(jsev_pkg::REQ_ARR_BEGIN));
		send_event(ev(jsev_pkg::REQ_NULL));
		send_event(ev(jsev_pkg::REQ_BOOL, 8'h00, 0, 0, 0, '0, 0, 1));
		send_event(ev(jsev_pkg::REQ_BOOL));
		send_event(ev(jsev_pkg::REQ_INT));
		send_event(ev(jsev_pkg::REQ_STRING, 8'h5C, 1, 1));
		send_event(ev(jsev_pkg::REQ_ARR_END));
		send_event(ev(jsev_pkg::REQ_OBJ_END));
		send_event(ev(jsev_pkg::REQ_FINISH));
		drain();
	endtask

	task automatic test_misuse();
		send_event(ev(jsev_pkg::REQ_CLEAR));
		send_event(ev(jsev_pkg::REQ_FINISH));           // no root value
		send_event(ev(jsev_pkg::REQ_CLEAR));
		send_event(ev(4'd15));                          // unknown request, ignored
		send_event(ev(jsev_pkg::REQ_OBJ_END));          // close with nothing open
		send_event(ev(jsev_pkg::REQ_CLEAR));
		send_event(ev(jsev_pkg::REQ_STRING, "x", 0, 1)); // byte without first
		send_event(ev(jsev_pkg::REQ_CLEAR));
		send_event(ev(jsev_pkg::REQ_ARR_BEGIN));
		send_event(ev(jsev_pkg::REQ_STRING, "y", 1, 0));
		send_event(ev(jsev_pkg::REQ_FINISH));           // string still open
		send_event(ev(jsev_pkg::REQ_CLEAR));
		send_event(ev(jsev_pkg::REQ_ARR_BEGIN));
		send_event(ev(jsev_pkg::REQ_FINISH));           // container still open
		send_event(ev(jsev_pkg::REQ_CLEAR));
		drain();
	endtask

	task automatic test_limits();
		write_reg(jsev_pkg::CFG_MAX_NEST, 32'd0);
		send_event(ev(jsev_pkg::REQ_ARR_BEGIN));        // too deep at once
		send_event(ev(jsev_pkg::REQ_CLEAR));
		drain();
		write_reg(jsev_pkg::CFG_MAX_NEST, 32'd63);      // clamps to stack depth
		write_reg(jsev_pkg::CFG_BUDGET, 32'd0);
		send_event(ev(jsev_pkg::REQ_NULL));             // too large at once
		send_event(ev(jsev_pkg::REQ_CLEAR));
		drain();
		write_reg(jsev_pkg::CFG_BUDGET, 32'd4);
		send_event(ev(jsev_pkg::REQ_ARR_BEGIN));
		send_event(ev(jsev_pkg::REQ_INT, 8'h00, 0, 0, 0, 64'd12345, 1)); // digits overflow budget
		send_event(ev(jsev_pkg::REQ_CLEAR));
		drain();
		write_reg(jsev_pkg::CFG_BUDGET, 32'hFFFF_FFFF);
		for (int i = 0; i < 33; i++) begin
			send_event(ev(jsev_pkg::REQ_ARR_BEGIN));    // hits the stack limit
		end
		send_event(ev(jsev_pkg::REQ_CLEAR));
		drain();
	endtask

	task automatic test_random(int count, logic [5:0] nest, logic [31:0] budget, bit squeeze);
		write_reg(jsev_pkg::CFG_MAX_NEST, {26'd0, nest});
		write_reg(jsev_pkg::CFG_BUDGET, budget);
		send_event(ev(jsev_pkg::REQ_CLEAR));
		for (int i = 0; i < count; i++) begin
			quiet = (i % 40) >= 30;           // bursts with no idling
			if (squeeze && i == count / 2) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			send_event(next_event());
		end
		quiet = 1'b0;
		drain();
	endtask

	initial begin
		lvl = 0;
		root_done = 1'b0;
		sticky = jsev_pkg::ST_OK;
		used = '0;
		piece_kind = jsev_pkg::PIECE_NONE;
		nest_cfg = jsev_pkg::MAX_NEST_RESET;
		budget_cfg = jsev_pkg::BUDGET_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_document();
		test_misuse();
		test_limits();
		test_random(58, 6'd32, 32'hFFFF_FFFF, 1'b1);
		test_random(58, 6'd3, 32'hFFFF_FFFF, 1'b0);
		test_random(58, 6'd63, 32'd90, 1'b0);
		test_random(58, 6'd1, 32'd300, 1'b0);

		if (fails == 0) begin
			$display("** json_stream_emitter_validator_top: PASSED **");
		end else begin
			$display("** json_stream_emitter_validator_top: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#30000000;
		$display("** json_stream_emitter_validator_top: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/jsev_pkg.sv
rtl/jsev_ram.sv
rtl/jsev_ctrl.sv
rtl/jsev_dp.sv
rtl/json_stream_emitter_validator_top.sv
tb/json_stream_emitter_validator_top_tb.sv
